// ----- design/eosp_pkg.sv -----
// ----------------------------------------------------------------------------
// eosp_pkg
// types, constants and the mode codes shared by the pressure pipeline
// ----------------------------------------------------------------------------
package eosp_pkg;

    localparam int FRAC = 20;
    localparam int IW   = 64;

    typedef logic signed [IW-1:0] ival_t;

    localparam ival_t LIM    = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam ival_t ONE_Q  = ival_t'(64'sd1 <<< FRAC);
    localparam ival_t C_TC   = ival_t'((64'sd170151343 <<< FRAC) / 64'sd1000000000);
    localparam ival_t C_K1   = ival_t'((64'sd37464 <<< FRAC) / 64'sd100000);
    localparam ival_t C_K2   = ival_t'((64'sd15422 <<< FRAC) / 64'sd10000);
    localparam ival_t C_K3   = ival_t'((64'sd26992 <<< FRAC) / 64'sd100000);

    typedef enum logic [1:0] {
        MODE_IDEAL = 2'd0,
        MODE_CS    = 2'd1,
        MODE_PR    = 2'd2,
        MODE_VDW   = 2'd3
    } eos_mode_t;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_GAS   = 3'd1,
        REG_ATTR  = 3'd2,
        REG_COVOL = 3'd3,
        REG_ACEN  = 3'd4,
        REG_MOLAR = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [30:0] density;
        logic [30:0] temperature;
    } eosp_in_t;

    typedef struct packed {
        logic signed [31:0] pressure;
        logic               math_fault;
    } eosp_out_t;

    typedef struct packed {
        eos_mode_t          mode;
        logic [30:0]        gas;
        logic [30:0]        attr;
        logic [30:0]        covol;
        logic signed [31:0] acen;
        logic [30:0]        molar;
    } eosp_cfg_t;

    function automatic ival_t clampv(input ival_t v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    function automatic ival_t qadd(input ival_t x, input ival_t y);
        logic signed [IW:0] s;
        s = (IW+1)'(clampv(x)) + (IW+1)'(clampv(y));
        if (s > (IW+1)'(LIM)) return LIM;
        if (s < -(IW+1)'(LIM)) return -LIM;
        return s[IW-1:0];
    endfunction

    function automatic ival_t qsub(input ival_t x, input ival_t y);
        return qadd(x, -clampv(y));
    endfunction

endpackage

// ----- design/eosp_mul.sv -----
// ----------------------------------------------------------------------------
// eosp_mul
// pipelined fixed point multiply: 4 partial products of 32x32, then normalize
// ----------------------------------------------------------------------------
module eosp_mul
    import eosp_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  ival_t x,
    input  ival_t y,
    output ival_t p
);
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic        neg_reg, neg2_reg;
    logic [63:0] lo_reg, hi_reg;
    logic [63:0] a, b;
    logic [63:0] mid, m;
    ival_t       r;

    always_comb begin
        a = clampv(x) < 0 ? 64'(-clampv(x)) : 64'(clampv(x));
        b = clampv(y) < 0 ? 64'(-clampv(y)) : 64'(clampv(y));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= 64'(a[31:0]) * 64'(b[31:0]);
            lh_reg  <= 64'(a[31:0]) * 64'(b[63:32]);
            hl_reg  <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg  <= 64'(a[63:32]) * 64'(b[63:32]);
            neg_reg <= (x < 0) != (y < 0);
        end
    end

    assign mid = {32'd0, ll_reg[63:32]} + {32'd0, lh_reg[31:0]} + {32'd0, hl_reg[31:0]};

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= {mid[31:0], ll_reg[31:0]};
            hi_reg   <= hh_reg + {32'd0, lh_reg[63:32]} + {32'd0, hl_reg[63:32]}
                        + {32'd0, mid[63:32]};
            neg2_reg <= neg_reg;
        end
    end

    always_comb begin
        if ((hi_reg >> FRAC) != 64'd0) m = 64'(LIM);
        else m = (lo_reg >> FRAC) | (hi_reg << (64 - FRAC));
        r = (m > 64'(LIM)) ? LIM : ival_t'(m);
        p = neg2_reg ? -r : r;
    end
endmodule

// ----- design/eosp_div.sv -----
// ----------------------------------------------------------------------------
// eosp_div
// pipelined restoring divider, one quotient bit per stage over 128 stages
// ----------------------------------------------------------------------------
module eosp_div
    import eosp_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  ival_t x,
    input  ival_t y,
    output ival_t q
);
    localparam int NS = 128;

    logic [63:0]  n_reg   [NS+1];
    logic [63:0]  d_reg   [NS+1];
    logic [64:0]  rem_reg [NS+1];
    logic [63:0]  q_reg   [NS+1];
    logic         sat_reg [NS+1];
    logic         neg_reg [NS+1];
    logic         zero_reg[NS+1];

    always_comb begin
        n_reg[0]    = clampv(x) < 0 ? 64'(-clampv(x)) : 64'(clampv(x));
        d_reg[0]    = 64'(clampv(y));
        rem_reg[0]  = '0;
        q_reg[0]    = '0;
        sat_reg[0]  = 1'b0;
        neg_reg[0]  = x < 0;
        zero_reg[0] = y <= 0;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        localparam int I = NS - 1 - s;
        localparam int J = I - FRAC;
        logic        bitv;
        logic [64:0] rs;
        logic [63:0] qs;
        logic        ge;
        always_comb begin
            bitv = (J < 0 || J > 63) ? 1'b0 : n_reg[s][(J < 0 || J > 63) ? 0 : J];
            rs   = {rem_reg[s][63:0], bitv};
            qs   = sat_reg[s] ? q_reg[s] : {q_reg[s][62:0], 1'b0};
            ge   = rs >= {1'b0, d_reg[s]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s+1]    <= n_reg[s];
                d_reg[s+1]    <= d_reg[s];
                rem_reg[s+1]  <= ge ? rs - {1'b0, d_reg[s]} : rs;
                q_reg[s+1]    <= (ge && !sat_reg[s]) ? (qs | 64'd1) : qs;
                sat_reg[s+1]  <= sat_reg[s] ||
                                 (((ge && !sat_reg[s]) ? (qs | 64'd1) : qs) > 64'(LIM));
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    always_comb begin
        ival_t r;
        r = (sat_reg[NS] || q_reg[NS] > 64'(LIM)) ? LIM : ival_t'(q_reg[NS]);
        q = zero_reg[NS] ? '0 : (neg_reg[NS] ? -r : r);
    end
endmodule

// ----- design/eosp_sqrt.sv -----
// ----------------------------------------------------------------------------
// eosp_sqrt
// pipelined digit-by-digit square root of x*2^FRAC, one root bit per stage
// ----------------------------------------------------------------------------
module eosp_sqrt
    import eosp_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  ival_t x,
    output ival_t r
);
    localparam int NS = 64;

    logic [63:0] v_reg   [NS+1];
    logic [65:0] rem_reg [NS+1];
    logic [63:0] root_reg[NS+1];

    always_comb begin
        v_reg[0]    = (x <= 0) ? 64'd0 : 64'(clampv(x));
        rem_reg[0]  = '0;
        root_reg[0] = '0;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        localparam int I  = NS - 1 - s;
        localparam int J1 = 2*I + 1 - FRAC;
        localparam int J0 = 2*I - FRAC;
        logic        b1, b0;
        logic [65:0] rs, tr;
        always_comb begin
            b1 = (J1 < 0 || J1 > 63) ? 1'b0 : v_reg[s][(J1 < 0 || J1 > 63) ? 0 : J1];
            b0 = (J0 < 0 || J0 > 63) ? 1'b0 : v_reg[s][(J0 < 0 || J0 > 63) ? 0 : J0];
            rs = {rem_reg[s][63:0], b1, b0};
            tr = {root_reg[s], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[s+1]    <= v_reg[s];
                rem_reg[s+1]  <= (rs >= tr) ? rs - tr : rs;
                root_reg[s+1] <= {root_reg[s][62:0], rs >= tr};
            end
        end
    end

    assign r = ival_t'(root_reg[NS]);
endmodule

// ----- design/equation_of_state_pressure.sv -----
// ----------------------------------------------------------------------------
// equation_of_state_pressure
// pipelined equation-of-state pressure for one density/temperature item
// ----------------------------------------------------------------------------
// one item enters per cycle while the output is not stalled. the latency is
// set by the chain of three 128-stage dividers and the 64-stage root in
// series, plus seven two-stage multiplies, one mid-pipe register and the
// output register, before the result shows on m_valid.
// every mode's datapath is computed for each item and the mode register picks
// at the end. pipeline advances only when the output register is free or
// being taken, so a stall freezes all stages, loses nothing and delays
// every item in flight.
// registers must be written only while the pipeline is empty.
module equation_of_state_pressure
    import eosp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  eosp_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output eosp_out_t          m_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int LM = 2;     // multiply latency
    localparam int LD = 128;   // divide latency
    localparam int LS = 64;    // root latency
    // stage boundaries for the dependency chain
    localparam int T1 = LM;             // b*rho, rho*r, b*r, c*a, c2*w, c3*w
    localparam int T2 = T1 + LM;        // rrt, brho^2, c3*w*w, a*rho*rho
    // length of the input delay lines, past their last tap
    localparam int TOT = T2 + 3*LD + LS + 6*LM + 2;

    eosp_cfg_t cfg_reg;
    logic      en;
    logic      v_reg [TOT+1];
    logic      mv_reg;
    eosp_out_t md_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode  <= MODE_IDEAL;
            cfg_reg.gas   <= 31'(ONE_Q);
            cfg_reg.attr  <= '0;
            cfg_reg.covol <= '0;
            cfg_reg.acen  <= '0;
            cfg_reg.molar <= 31'(ONE_Q);
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_MODE:  cfg_reg.mode  <= eos_mode_t'(cfg_data[1:0]);
                REG_GAS:   cfg_reg.gas   <= cfg_data[30:0];
                REG_ATTR:  cfg_reg.attr  <= cfg_data[30:0];
                REG_COVOL: cfg_reg.covol <= cfg_data[30:0];
                REG_ACEN:  cfg_reg.acen  <= cfg_data;
                REG_MOLAR: cfg_reg.molar <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign en      = !mv_reg || m_ready;
    assign s_ready = en;

    ival_t rho, t, r, a, b, w, m;
    assign rho = ival_t'(s_data.density);
    assign t   = ival_t'(s_data.temperature);
    assign r   = ival_t'(cfg_reg.gas);
    assign a   = ival_t'(cfg_reg.attr);
    assign b   = ival_t'(cfg_reg.covol);
    assign w   = ival_t'(cfg_reg.acen);
    assign m   = ival_t'(cfg_reg.molar);

    // stage 0 products
    ival_t p_rhor, p_brho, p_br, p_ca, p_c2w, p_c3w, p_rhob, p_mm, p_arho;
    eosp_mul u_m0 (.aclk, .en, .x(rho), .y(r),    .p(p_rhor));
    eosp_mul u_m1 (.aclk, .en, .x(b),   .y(rho),  .p(p_brho));
    eosp_mul u_m2 (.aclk, .en, .x(b),   .y(r),    .p(p_br));
    eosp_mul u_m3 (.aclk, .en, .x(C_TC),.y(a),    .p(p_ca));
    eosp_mul u_m4 (.aclk, .en, .x(C_K2),.y(w),    .p(p_c2w));
    eosp_mul u_m5 (.aclk, .en, .x(C_K3),.y(w),    .p(p_c3w));
    eosp_mul u_m6 (.aclk, .en, .x(rho), .y(b),    .p(p_rhob));
    eosp_mul u_m7 (.aclk, .en, .x(m),   .y(m),    .p(p_mm));
    eosp_mul u_m8 (.aclk, .en, .x(a),   .y(rho),  .p(p_arho));

    // delayed copies of inputs
    ival_t t_d [TOT+1];
    ival_t rho_d [TOT+1];
    ival_t a_d [TOT+1];
    ival_t w_d [TOT+1];
    ival_t m_d [TOT+1];
    assign t_d[0] = t;
    assign rho_d[0] = rho;
    assign a_d[0] = a;
    assign w_d[0] = w;
    assign m_d[0] = m;
    for (genvar i = 0; i < TOT; i++) begin : g_dl
        always_ff @(posedge aclk) begin
            if (en) begin
                t_d[i+1] <= t_d[i];
                rho_d[i+1] <= rho_d[i];
                a_d[i+1] <= a_d[i];
                w_d[i+1] <= w_d[i];
                m_d[i+1] <= m_d[i];
            end
        end
    end

    // stage T1
    ival_t p_rrt, p_bb, p_k3ww, p_arr, p_c3ww;
    eosp_mul u_m9  (.aclk, .en, .x(p_rhor), .y(t_d[T1]),   .p(p_rrt));
    eosp_mul u_m10 (.aclk, .en, .x(p_brho), .y(p_brho),    .p(p_bb));
    eosp_mul u_m11 (.aclk, .en, .x(p_c3w),  .y(w_d[T1]),   .p(p_c3ww));
    eosp_mul u_m12 (.aclk, .en, .x(p_arho), .y(rho_d[T1]), .p(p_arr));

    ival_t tc_q;
    eosp_div u_d1 (.aclk, .en, .x(p_ca),   .y(p_br),                .q(tc_q));

    // carry T1-born values to T1+LD
    localparam int TA = T1 + LD;
    ival_t brho_d [LD+1], br_d [LD+1], c2w_d [LD+1], c3ww_d[LD+1], rhob_d[LD+1], mm_d[LD+1];
    ival_t rrt_d [LD+1], bb_d [LD+1], arr_d [LD+1];
    assign brho_d[0] = p_brho;
    assign br_d[0]   = p_br;
    assign c2w_d[0]  = p_c2w;
    assign rhob_d[0] = p_rhob;
    assign mm_d[0]   = p_mm;
    assign rrt_d[0]  = '0;
    assign bb_d[0]   = '0;
    assign arr_d[0]  = '0;
    assign c3ww_d[0] = '0;
    for (genvar i = 0; i < LD; i++) begin : g_da
        always_ff @(posedge aclk) begin
            if (en) begin
                brho_d[i+1] <= brho_d[i];
                br_d[i+1]   <= br_d[i];
                c2w_d[i+1]  <= c2w_d[i];
                rhob_d[i+1] <= rhob_d[i];
                mm_d[i+1]   <= mm_d[i];
                rrt_d[i+1]  <= (i == LM) ? p_rrt  : rrt_d[i];
                bb_d[i+1]   <= (i == LM) ? p_bb   : bb_d[i];
                arr_d[i+1]  <= (i == LM) ? p_arr  : arr_d[i];
                c3ww_d[i+1] <= (i == LM) ? p_c3ww : c3ww_d[i];
            end
        end
    end

    // at TA: tc ready, x from b*rho; derive denominators and k
    ival_t brho_a, x_a, d1pr, d2pr, d1vw, k_a, beta_a;
    always_comb begin
        brho_a = brho_d[LD];
        // b*rho/4 is a shift, truncated toward zero
        x_a    = (brho_a < 0) ? -((-brho_a) >>> 2) : (brho_a >>> 2);
        d1pr   = qsub(ONE_Q, brho_a);
        d2pr   = qsub(qadd(ONE_Q, qadd(brho_a, brho_a)), bb_d[LD]);
        d1vw   = qsub(m_d[TA], rhob_d[LD]);
        k_a    = qsub(qadd(C_K1, c2w_d[LD]), c3ww_d[LD]);
        beta_a = qsub(ONE_Q, x_a);
    end

    // registered stage at TA
    ival_t x_r, beta_r, tc_r, d1pr_r, d2pr_r, d1vw_r, k_r, br_r, mm_r, rrt_r, arr_r;
    always_ff @(posedge aclk) begin
        if (en) begin
            x_r    <= x_a;
            beta_r <= beta_a;
            tc_r   <= tc_q;
            d1pr_r <= d1pr;
            d2pr_r <= d2pr;
            d1vw_r <= d1vw;
            k_r    <= k_a;
            br_r   <= br_d[LD];
            mm_r   <= mm_d[LD];
            rrt_r  <= rrt_d[LD];
            arr_r  <= arr_d[LD];
        end
    end
    localparam int TB = TA + 1;

    // mode 1 polynomial: x2, beta^2 at TB; x3, den at TB+LM
    ival_t x2, bt2, x3, den, x2_d, x_d2, one_x;
    eosp_mul u_m13 (.aclk, .en, .x(x_r), .y(x_r), .p(x2));
    eosp_mul u_m14 (.aclk, .en, .x(beta_r), .y(beta_r), .p(bt2));
    ival_t xs [2*LM+1], bs [LM+1];
    assign xs[0] = x_r;
    assign bs[0] = beta_r;
    for (genvar i = 0; i < 2*LM; i++) begin : g_xs
        always_ff @(posedge aclk) if (en) xs[i+1] <= xs[i];
    end
    for (genvar i = 0; i < LM; i++) begin : g_bs
        always_ff @(posedge aclk) if (en) bs[i+1] <= bs[i];
    end
    eosp_mul u_m15 (.aclk, .en, .x(x2),  .y(xs[LM]), .p(x3));
    eosp_mul u_m16 (.aclk, .en, .x(bt2), .y(bs[LM]), .p(den));
    ival_t x2s [LM+1];
    assign x2s[0] = x2;
    for (genvar i = 0; i < LM; i++) begin : g_x2
        always_ff @(posedge aclk) if (en) x2s[i+1] <= x2s[i];
    end
    assign x2_d  = x2s[LM];
    assign x_d2  = xs[2*LM];
    assign one_x = qsub(qadd(qadd(ONE_Q, x_d2), x2_d), x3);

    // mode 2 root path: t/tc from TB, root, then s
    ival_t ttc, sq;
    eosp_div  u_d2 (.aclk, .en, .x(t_d[TB]), .y(tc_r), .q(ttc));
    eosp_sqrt u_s0 (.aclk, .en, .x(ttc), .r(sq));
    localparam int TC = TB + LD + LS;   // sq valid
    ival_t ks [LD+LS+1];
    assign ks[0] = k_r;
    for (genvar i = 0; i < LD+LS; i++) begin : g_ks
        always_ff @(posedge aclk) if (en) ks[i+1] <= ks[i];
    end
    ival_t kk, s_v, as1, as2, as3, att;
    eosp_mul u_m17 (.aclk, .en, .x(ks[LD+LS]), .y(qsub(ONE_Q, sq)), .p(kk));
    assign s_v = qadd(ONE_Q, kk);
    ival_t sv_d [LM+1];
    assign sv_d[0] = s_v;
    for (genvar i = 0; i < LM; i++) begin : g_sv
        always_ff @(posedge aclk) if (en) sv_d[i+1] <= sv_d[i];
    end
    eosp_mul u_m18 (.aclk, .en, .x(a_d[TC+LM]),   .y(s_v),          .p(as1));
    eosp_mul u_m19 (.aclk, .en, .x(as1),          .y(sv_d[LM]),     .p(as2));
    eosp_mul u_m20 (.aclk, .en, .x(as2),          .y(rho_d[TC+3*LM]), .p(as3));
    eosp_mul u_m21 (.aclk, .en, .x(as3),          .y(rho_d[TC+4*LM]), .p(att));
    localparam int TD = TC + 5*LM;      // att valid

    // final divisions of modes 1 to 3, aligned to start at TD
    localparam int DL = TD - TB;
    ival_t rrt_s [DL+1], arr_s [DL+1], d1pr_s [DL+1], d2pr_s [DL+1], d1vw_s [DL+1];
    ival_t mm_s [DL+1], br_s [DL+1], tc_s [DL+1];
    assign rrt_s[0]  = rrt_r;
    assign arr_s[0]  = arr_r;
    assign d1pr_s[0] = d1pr_r;
    assign d2pr_s[0] = d2pr_r;
    assign d1vw_s[0] = d1vw_r;
    assign mm_s[0]   = mm_r;
    assign br_s[0]   = br_r;
    assign tc_s[0]   = tc_r;
    for (genvar i = 0; i < DL; i++) begin : g_fs
        always_ff @(posedge aclk) begin
            if (en) begin
                rrt_s[i+1]  <= rrt_s[i];
                arr_s[i+1]  <= arr_s[i];
                d1pr_s[i+1] <= d1pr_s[i];
                d2pr_s[i+1] <= d2pr_s[i];
                d1vw_s[i+1] <= d1vw_s[i];
                mm_s[i+1]   <= mm_s[i];
                br_s[i+1]   <= br_s[i];
                tc_s[i+1]   <= tc_s[i];
            end
        end
    end
    // mode 1 num/den, aligned
    localparam int CL = DL - 2*LM;
    ival_t num_s [CL+1], den_s [CL+1];
    assign num_s[0] = one_x;
    assign den_s[0] = den;
    for (genvar i = 0; i < CL; i++) begin : g_cs
        always_ff @(posedge aclk) if (en) begin
            num_s[i+1] <= num_s[i];
            den_s[i+1] <= den_s[i];
        end
    end

    ival_t q_cs, q_pr1, q_pr2, q_vw1, q_vw2;
    eosp_div u_d3 (.aclk, .en, .x(num_s[CL]),  .y(den_s[CL]),  .q(q_cs));
    eosp_div u_d4 (.aclk, .en, .x(rrt_s[DL]),  .y(d1pr_s[DL]), .q(q_pr1));
    eosp_div u_d5 (.aclk, .en, .x(att),        .y(d2pr_s[DL]), .q(q_pr2));
    eosp_div u_d6 (.aclk, .en, .x(rrt_s[DL]),  .y(d1vw_s[DL]), .q(q_vw1));
    eosp_div u_d7 (.aclk, .en, .x(arr_s[DL]),  .y(mm_s[DL]),   .q(q_vw2));
    localparam int TE = TD + LD;

    // carry for final stage
    ival_t rrt_e [LD+1], arr_e [LD+1], den_e [LD+1];
    logic  flt2_e [LD+1];
    assign rrt_e[0]  = rrt_s[DL];
    assign arr_e[0]  = arr_s[DL];
    assign den_e[0]  = den_s[CL];
    assign flt2_e[0] = br_s[DL] <= 0 || d1pr_s[DL] <= 0 || d2pr_s[DL] <= 0 || tc_s[DL] <= 0;
    logic flt3_e [LD+1];
    assign flt3_e[0] = d1vw_s[DL] <= 0 || mm_s[DL] <= 0;
    for (genvar i = 0; i < LD; i++) begin : g_es
        always_ff @(posedge aclk) if (en) begin
            rrt_e[i+1]  <= rrt_e[i];
            arr_e[i+1]  <= arr_e[i];
            den_e[i+1]  <= den_e[i];
            flt2_e[i+1] <= flt2_e[i];
            flt3_e[i+1] <= flt3_e[i];
        end
    end
    ival_t m1p;
    eosp_mul u_m22 (.aclk, .en, .x(rrt_e[LD]), .y(q_cs), .p(m1p));
    ival_t arr_f [LM+1], rrt_f [LM+1], pr_f [LM+1], vw_f [LM+1], den_f [LM+1];
    logic  f2_f [LM+1], f3_f [LM+1];
    assign arr_f[0] = arr_e[LD];
    assign rrt_f[0] = rrt_e[LD];
    assign pr_f[0]  = qsub(q_pr1, q_pr2);
    assign vw_f[0]  = qsub(q_vw1, q_vw2);
    assign den_f[0] = den_e[LD];
    assign f2_f[0]  = flt2_e[LD];
    assign f3_f[0]  = flt3_e[LD];
    for (genvar i = 0; i < LM; i++) begin : g_ff
        always_ff @(posedge aclk) if (en) begin
            arr_f[i+1] <= arr_f[i];
            rrt_f[i+1] <= rrt_f[i];
            pr_f[i+1]  <= pr_f[i];
            vw_f[i+1]  <= vw_f[i];
            den_f[i+1] <= den_f[i];
            f2_f[i+1]  <= f2_f[i];
            f3_f[i+1]  <= f3_f[i];
        end
    end
    localparam int TF = TE + LM;

    // final selection and word clamp
    ival_t     psel;
    logic      fsel;
    eosp_out_t res;
    localparam ival_t WMAX = 64'sh7FFF_FFFF;
    always_comb begin
        fsel = 1'b0;
        unique case (cfg_reg.mode)
            MODE_IDEAL: psel = rrt_f[LM];
            MODE_CS: begin
                fsel = den_f[LM] <= 0;
                psel = qsub(m1p, arr_f[LM]);
            end
            MODE_PR: begin
                fsel = f2_f[LM];
                psel = pr_f[LM];
            end
            MODE_VDW: begin
                fsel = f3_f[LM];
                psel = vw_f[LM];
            end
            default: psel = '0;
        endcase
        if (fsel || psel > WMAX) res.pressure = 32'sh7FFF_FFFF;
        else if (psel < -WMAX - 1) res.pressure = 32'sh8000_0000;
        else res.pressure = psel[31:0];
        res.math_fault = fsel;
    end

    // valid bits follow the items through the pipeline
    assign v_reg[0] = s_valid;
    for (genvar i = 0; i < TF; i++) begin : g_v
        always_ff @(posedge aclk) begin
            if (!aresetn) v_reg[i+1] <= 1'b0;
            else if (en) v_reg[i+1] <= v_reg[i];
        end
    end
    for (genvar i = TF; i < TOT; i++) begin : g_vu
        assign v_reg[i+1] = 1'b0;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en) begin
            mv_reg <= v_reg[TF];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) md_reg <= res;
    end

    assign m_valid = mv_reg;
    assign m_data  = md_reg;
endmodule

// ----- design/eosp_check.sv -----
// ----------------------------------------------------------------------------
// eosp_check
// port-level checks for the pressure pipeline
// ----------------------------------------------------------------------------
module eosp_check
    import eosp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input eosp_out_t m_data
);
    // a fault always reports the saturated pressure
    a_fault_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.math_fault |-> m_data.pressure == 32'sh7FFF_FFFF)
        else $error("fault without saturated pressure");

    // a waiting result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // input is taken whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready while output empty");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
endmodule

bind equation_of_state_pressure eosp_check u_eosp_check (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
